/* design/char_and_bigram_histogram_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the character and bigram histogram
// Shared helpers that wrap clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef CHAR_AND_BIGRAM_HISTOGRAM_DEFINES_SVH
`define CHAR_AND_BIGRAM_HISTOGRAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHBH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/chbh_pkg.sv */
// ----------------------------------------------------------------------------
// Character and bigram histogram package
// Shared widths, codes, state machine type, control structs and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package chbh_pkg;

   localparam int COUNT_WIDTH     = 32;
   localparam int OUT_WIDTH       = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int BYTE_DEPTH      = 2 ** BYTE_WIDTH;
   localparam int PAIR_ADDR_WIDTH = 2 * BYTE_WIDTH;
   localparam int PAIR_DEPTH      = 2 ** PAIR_ADDR_WIDTH;
   localparam int OP_WIDTH        = 2;

   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [OUT_WIDTH-1:0]       out_count_type;
   typedef logic [BYTE_WIDTH-1:0]      byte_type;
   typedef logic [PAIR_ADDR_WIDTH-1:0] pair_addr_type;
   typedef logic [OP_WIDTH-1:0]        op_type;

   localparam op_type OP_COUNT      = 2'd0;
   localparam op_type OP_QUERY_BYTE = 2'd1;
   localparam op_type OP_QUERY_PAIR = 2'd2;
   localparam op_type OP_RESERVED   = 2'd3;

   localparam count_type     COUNT_ONE = count_type'(1);
   localparam count_type     COUNT_MAX = '1;
   localparam out_count_type OUT_MAX   = '1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic lookup;
      logic update;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic in_op_known;
      logic item_is_count;
   } ctrl_status_type;

   function automatic byte_type fold_lower(input byte_type b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   function automatic count_type sat_bump(input count_type v);
      if (v == COUNT_MAX) begin
         return v;
      end
      return v + COUNT_ONE;
   endfunction

   function automatic out_count_type clip_out(input count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return wide[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/chbh_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/chbh_ctrl.sv */
// ----------------------------------------------------------------------------
// Histogram controller
// Sequences the clearing pass, item capture, lookup, write-back and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_and_bigram_histogram_defines.svh"

module chbh_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire chbh_pkg::ctrl_status_type status,
   output chbh_pkg::ctrl_cmd_type         cmd
);

   chbh_pkg::state_type state_ff;
   chbh_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                slot_free;
   logic                accept;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         chbh_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = chbh_pkg::ST_IDLE;
            end
         end
         chbh_pkg::ST_IDLE, chbh_pkg::ST_UPDATE: begin
            state_in = (accept && status.in_op_known) ? chbh_pkg::ST_LOOKUP
                                                      : chbh_pkg::ST_IDLE;
         end
         chbh_pkg::ST_LOOKUP: begin
            state_in = status.item_is_count ? chbh_pkg::ST_UPDATE
                                            : chbh_pkg::ST_RESULT;
         end
         chbh_pkg::ST_RESULT: begin
            if (slot_free) begin
               state_in = (accept && status.in_op_known) ? chbh_pkg::ST_LOOKUP
                                                         : chbh_pkg::ST_IDLE;
            end
         end
         default: state_in = chbh_pkg::ST_CLEAR;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         chbh_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         chbh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         chbh_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         chbh_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            req_tready = 1'b1;
         end
         chbh_pkg::ST_RESULT: begin
            cmd.load_rsp = slot_free;
            req_tready   = slot_free;
         end
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
      cmd.capture = req_tvalid && req_tready;
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chbh_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `CHBH_ASSERT_NOW(a_no_accept_in_clear, clock, reset, (state_ff == chbh_pkg::ST_CLEAR), !req_tready, "item accepted during clearing pass")
   `CHBH_ASSERT_NEXT(a_count_writes_back, clock, reset, (state_ff == chbh_pkg::ST_LOOKUP && status.item_is_count), (state_ff == chbh_pkg::ST_UPDATE), "counted byte lookup not followed by write-back")
   `CHBH_ASSERT_NOW(a_result_slot_free, clock, reset, cmd.load_rsp, (!rsp_valid_ff || rsp_tready), "result loaded over an untaken result")

endmodule

`default_nettype wire

/* design/chbh_datapath.sv */
// ----------------------------------------------------------------------------
// Histogram datapath
// Item registers, case folding, both count memories and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chbh_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire chbh_pkg::op_type        in_op,
   input  wire chbh_pkg::byte_type      in_char,
   input  wire chbh_pkg::byte_type      in_second,
   input  wire logic                    in_last,
   input  wire chbh_pkg::ctrl_cmd_type  cmd,
   output chbh_pkg::ctrl_status_type    status,
   output chbh_pkg::out_count_type      rsp_count,
   output logic                         rsp_was_pair
);

   chbh_pkg::op_type        op_ff;
   chbh_pkg::byte_type      char_ff;
   chbh_pkg::byte_type      second_ff;
   logic                    last_ff;
   chbh_pkg::byte_type      prev_byte_ff;
   logic                    prev_valid_ff;
   chbh_pkg::pair_addr_type clear_ff;
   chbh_pkg::out_count_type rsp_count_ff;
   logic                    rsp_was_pair_ff;

   chbh_pkg::byte_type      fold_byte;
   logic                    item_is_count;
   chbh_pkg::byte_type      byte_rd_addr;
   chbh_pkg::byte_type      byte_wr_addr;
   chbh_pkg::count_type     byte_rd_data;
   chbh_pkg::count_type     byte_wr_data;
   logic                    byte_wr_en;
   chbh_pkg::pair_addr_type pair_rd_addr;
   chbh_pkg::pair_addr_type pair_wr_addr;
   chbh_pkg::count_type     pair_rd_data;
   chbh_pkg::count_type     pair_wr_data;
   logic                    pair_wr_en;

   assign fold_byte     = chbh_pkg::fold_lower(char_ff);
   assign item_is_count = (op_ff == chbh_pkg::OP_COUNT);

   always_comb begin
      unique case (in_op) inside
         chbh_pkg::OP_COUNT, chbh_pkg::OP_QUERY_BYTE, chbh_pkg::OP_QUERY_PAIR:
            status.in_op_known = 1'b1;
         default:
            status.in_op_known = 1'b0;
      endcase
      status.item_is_count = item_is_count;
      status.clear_last    = (clear_ff == '1);
   end

   // Counted bytes read the folded address; queries read the raw one.
   assign byte_rd_addr = item_is_count ? fold_byte : char_ff;
   assign pair_rd_addr = item_is_count ? {prev_byte_ff, fold_byte} : {char_ff, second_ff};

   assign byte_wr_en   = cmd.clear_step || cmd.update;
   assign byte_wr_addr = cmd.clear_step ? clear_ff[chbh_pkg::BYTE_WIDTH-1:0] : fold_byte;
   assign byte_wr_data = cmd.clear_step ? '0 : chbh_pkg::sat_bump(byte_rd_data);

   assign pair_wr_en   = cmd.clear_step || (cmd.update && prev_valid_ff);
   assign pair_wr_addr = cmd.clear_step ? clear_ff : {prev_byte_ff, fold_byte};
   assign pair_wr_data = cmd.clear_step ? '0 : chbh_pkg::sat_bump(pair_rd_data);

   chbh_ram #(
      .WIDTH (chbh_pkg::COUNT_WIDTH),
      .DEPTH (chbh_pkg::BYTE_DEPTH)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (byte_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   chbh_ram #(
      .WIDTH (chbh_pkg::COUNT_WIDTH),
      .DEPTH (chbh_pkg::PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   // Control state: line tracking and the clearing address.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff  <= '0;
         prev_valid_ff <= 1'b0;
         clear_ff      <= '0;
      end else begin
         if (cmd.clear_step) begin
            clear_ff <= clear_ff + chbh_pkg::pair_addr_type'(1);
         end
         if (cmd.update) begin
            if (last_ff) begin
               prev_valid_ff <= 1'b0;
            end else begin
               prev_byte_ff  <= fold_byte;
               prev_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= in_op;
         char_ff   <= in_char;
         second_ff <= in_second;
         last_ff   <= in_last;
      end
      if (cmd.load_rsp) begin
         rsp_was_pair_ff <= (op_ff == chbh_pkg::OP_QUERY_PAIR);
         rsp_count_ff    <= chbh_pkg::clip_out((op_ff == chbh_pkg::OP_QUERY_PAIR)
                                               ? pair_rd_data : byte_rd_data);
      end
   end

   assign rsp_count    = rsp_count_ff;
   assign rsp_was_pair = rsp_was_pair_ff;

endmodule

`default_nettype wire

/* design/char_and_bigram_histogram.sv */
// ----------------------------------------------------------------------------
// Character and bigram histogram
// Counts case-folded text bytes and in-line byte pairs; answers count queries.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the 256-entry
// character store and the 65536-entry pair store, one pair entry per cycle,
// and takes no transaction until that pass is done. Each text byte is
// folded to lower case (only ASCII A to Z change) and counted; it also bumps
// the pair formed with the previous folded byte of the same line, and tlast
// on a counted byte closes the line. Counters saturate at their maximum.
// A query transaction returns the count of a raw byte or raw byte pair with no
// case folding, so an upper-case letter always reads zero; a counted byte
// gives no result and the unused op code is dropped. An item has a lookup
// state for the read of both count memories, then an update state for the
// write-back or a result state for the load of the result register, and the
// next item is accepted during that second state. The registered read of the
// count memories sets these steps, since a count arrives in the cycle after
// its address. An item with the unused op code is dropped at acceptance.
// A query stalls in its result state while an untaken result is held.
// ----------------------------------------------------------------------------
`default_nettype none

module char_and_bigram_histogram (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] char_byte, [15:8] second_byte
   input  wire logic [1:0]  req_tuser,  // [1:0] op
   input  wire logic        req_tlast,  // line_end
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [31:0] count
   output logic             rsp_tuser   // was_pair
);

   chbh_pkg::ctrl_cmd_type    cmd;
   chbh_pkg::ctrl_status_type status;

   // The controller owns the handshakes and the result-valid flag.
   chbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the item, the two count memories and the result.
   chbh_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_op        (req_tuser),
      .in_char      (req_tdata[7:0]),
      .in_second    (req_tdata[15:8]),
      .in_last      (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .rsp_count    (rsp_tdata),
      .rsp_was_pair (rsp_tuser)
   );

endmodule

`default_nettype wire
